/* hw/rtl/tlbl_pkg.sv */
// Shared types and constants for the fully associative TLB tag store.
// Used by tlbl_cell and tlb_lru_lookup_top; depends on nothing else.
package tlbl_pkg;

  // Fixed field widths.
  localparam int ADDR_W     = 32;
  localparam int OUT_SLOT_W = 4;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 1;

  // Default table depth.
  localparam int DEF_TABLE_ENTRIES = 16;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_PAGE_OFFSET = 5'd12;
  localparam logic [CFG_W-1:0] RST_ENTRIES     = 5'd16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES     = 1'd1;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

endpackage

/* hw/rtl/tlb_lru_lookup_top.sv */
// Top level of the fully associative TLB tag store with LRU replacement.
// Instantiates a chain of tlbl_cell slots; imports tlbl_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one access address per item.
//   Result channel (out_valid/out_stall) returns hit, slot index, eviction
//   information and the running miss total, one result per item.
//   Configuration writes (cfg_valid/cfg_ready, always ready) set the page
//   offset (index 0) and the number of active slots (index 1); the user
//   must make them while the block is idle, which the block does not enforce.
// Timing:
//   An accepted item sends a probe down the row of TABLE_ENTRIES cells, one
//   cell per cycle; the sequencer then moves from its search step to its
//   finish step, which applies the update and loads the result register.
//   A new item is taken only after the previous one has finished, so items
//   never overlap in the cell row.
//   in_stall is high while an item is in flight.
// Reset:
//   All slots become empty with rank zero, the miss total clears and the
//   registers return to offset 12 and 16 active slots.
// Stall:
//   A stalled result is held; a finished item waits in its last step until
//   the result register is free, and no new item is accepted meanwhile.
module tlb_lru_lookup_top #(
  parameter int TABLE_ENTRIES = tlbl_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tlbl_pkg::ADDR_W-1:0]       in_access_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [tlbl_pkg::OUT_SLOT_W-1:0]   out_slot_index,
  output logic                              out_evicted_valid,
  output logic [tlbl_pkg::ADDR_W-1:0]       out_evicted_page,
  output logic [tlbl_pkg::ADDR_W-1:0]       out_miss_total,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlbl_pkg::CFG_W-1:0]        cfg_data
);
  import tlbl_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int RANK_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int REC_W  = 2 * ADDR_W + 2 + 3 * SLOT_W + 2 * RANK_W;
  localparam int UPD_W  = ADDR_W + 2 + SLOT_W + RANK_W;

  typedef struct packed {
    logic [ADDR_W-1:0] page;
    logic              found;
    logic [SLOT_W-1:0] found_slot;
    logic [RANK_W-1:0] found_rank;
    logic              empty;
    logic [SLOT_W-1:0] empty_slot;
    logic [RANK_W-1:0] worst_rank;
    logic [SLOT_W-1:0] worst_slot;
    logic [ADDR_W-1:0] worst_page;
  } probe_t;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] target;
    logic              was_valid;
    logic [RANK_W-1:0] old_rank;
    logic [ADDR_W-1:0] page;
  } upd_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [CFG_W-1:0]  offset_r;
  logic [CFG_W-1:0]  entries_r;
  logic [CNT_W-1:0]  n_active;
  logic [ADDR_W-1:0] miss_r;
  logic [ADDR_W-1:0] miss_nxt;
  logic              accept;
  logic              fire;
  logic              last_vld;
  probe_t            launch;
  probe_t            last_rec;
  upd_t              upd;
  logic              ev_valid;
  logic [ADDR_W-1:0] ev_page;

  logic [TABLE_ENTRIES-1:0]            vld_vec;
  logic [TABLE_ENTRIES-1:0][REC_W-1:0] rec_vec;

  logic                        out_valid_r;
  logic                        hit_r;
  logic [OUT_SLOT_W-1:0]       slot_r;
  logic                        ev_valid_r;
  logic [ADDR_W-1:0]           ev_page_r;
  logic [ADDR_W-1:0]           miss_out_r;

  // Configuration registers; the port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= RST_PAGE_OFFSET;
      entries_r <= RST_ENTRIES;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAGE_OFFSET: offset_r  <= cfg_data;
        CFG_ENTRIES:     entries_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Active slot count, clamped to one and to the table depth.
  always_comb begin
    if (entries_r == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(entries_r) > 32'(TABLE_ENTRIES)) begin
      n_active = CNT_W'(TABLE_ENTRIES);
    end else begin
      n_active = CNT_W'(entries_r);
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SEARCH;
      ST_SEARCH: if (last_vld) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall = 1'b1;
    fire     = 1'b0;
    case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_SEARCH: in_stall = 1'b1;
      ST_FINISH: fire     = !out_valid_r || !out_stall;
      default:   in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign accept = in_valid && !in_stall;

  // Probe record entering the first cell.
  always_comb begin
    launch      = '0;
    launch.page = in_access_address >> offset_r;
  end

  // The row of slot cells.
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      logic             cin_vld;
      logic [REC_W-1:0] cin;
      if (gi == 0) begin : g_head
        assign cin_vld = accept;
        assign cin     = REC_W'(launch);
      end else begin : g_link
        assign cin_vld = vld_vec[gi-1];
        assign cin     = rec_vec[gi-1];
      end
      tlbl_cell #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX           (gi)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .n_active    (n_active),
        .rec_in_vld  (cin_vld),
        .rec_in      (cin),
        .rec_out_vld (vld_vec[gi]),
        .rec_out     (rec_vec[gi]),
        .upd_in      (UPD_W'(upd))
      );
    end
  endgenerate

  assign last_vld = vld_vec[TABLE_ENTRIES-1];
  assign last_rec = probe_t'(rec_vec[TABLE_ENTRIES-1]);

  // Replacement decision from the record that left the last cell.
  always_comb begin
    upd      = '0;
    ev_valid = 1'b0;
    ev_page  = '0;
    upd.vld  = fire;
    upd.page = last_rec.page;
    if (last_rec.found) begin
      upd.target    = last_rec.found_slot;
      upd.was_valid = 1'b1;
      upd.old_rank  = last_rec.found_rank;
    end else if (last_rec.empty) begin
      upd.target    = last_rec.empty_slot;
      upd.was_valid = 1'b0;
    end else begin
      upd.target    = last_rec.worst_slot;
      upd.was_valid = 1'b1;
      upd.old_rank  = last_rec.worst_rank;
      ev_valid      = 1'b1;
      ev_page       = last_rec.worst_page;
    end
  end

  // Saturating miss counter.
  always_comb begin
    miss_nxt = miss_r;
    if (!last_rec.found && (miss_r != '1)) begin
      miss_nxt = miss_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_r <= '0;
    end else if (fire) begin
      miss_r <= miss_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hit_r      <= last_rec.found;
      slot_r     <= OUT_SLOT_W'(upd.target);
      ev_valid_r <= ev_valid;
      ev_page_r  <= ev_page;
      miss_out_r <= miss_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_slot_index    = slot_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;
  assign out_miss_total    = miss_out_r;

`ifndef SYNTHESIS
  // Only one probe travels along the row at a time.
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld_vec))
    else $error("more than one probe in the cell row");

  // The probe leaves the row only while the sequencer is searching.
  a_probe_state: assert property (@(posedge clk) disable iff (!rst_n)
    last_vld |-> (state_r == ST_SEARCH))
    else $error("probe left the row outside the search step");

  // A new result appears only from the finishing step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result loaded outside the finishing step");

  // The miss total never goes backwards.
  a_miss_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (miss_r >= $past(miss_r)))
    else $error("miss total decreased");
`endif

endmodule

/* hw/rtl/tlbl_cell.sv */
// One slot of the TLB tag store: holds valid, page and recency rank.
// Passes the lookup probe record to its neighbour; imports tlbl_pkg.
module tlbl_cell #(
  parameter int TABLE_ENTRIES = tlbl_pkg::DEF_TABLE_ENTRIES,
  parameter int IDX = 0,
  localparam int SLOT_W = $clog2(TABLE_ENTRIES),
  localparam int RANK_W = $clog2(TABLE_ENTRIES),
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1),
  localparam int REC_W  = 2 * tlbl_pkg::ADDR_W + 2 + 3 * SLOT_W + 2 * RANK_W,
  localparam int UPD_W  = tlbl_pkg::ADDR_W + 2 + SLOT_W + RANK_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] n_active,
  input  logic             rec_in_vld,
  input  logic [REC_W-1:0] rec_in,
  output logic             rec_out_vld,
  output logic [REC_W-1:0] rec_out,
  input  logic [UPD_W-1:0] upd_in
);
  import tlbl_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] page;
    logic              found;
    logic [SLOT_W-1:0] found_slot;
    logic [RANK_W-1:0] found_rank;
    logic              empty;
    logic [SLOT_W-1:0] empty_slot;
    logic [RANK_W-1:0] worst_rank;
    logic [SLOT_W-1:0] worst_slot;
    logic [ADDR_W-1:0] worst_page;
  } probe_t;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] target;
    logic              was_valid;
    logic [RANK_W-1:0] old_rank;
    logic [ADDR_W-1:0] page;
  } upd_t;

  localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(IDX);
  localparam logic [CNT_W-1:0]  MY_CNT   = CNT_W'(IDX);
  localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(TABLE_ENTRIES - 1);
  localparam bit                FIRST    = (IDX == 0);

  logic              valid_r;
  logic [ADDR_W-1:0] page_r;
  logic [RANK_W-1:0] rank_r;
  logic              vld_r;
  probe_t            rec_r;
  probe_t            rec_nxt;
  probe_t            rin;
  upd_t              upd;
  logic              active;

  assign rin    = probe_t'(rec_in);
  assign upd    = upd_t'(upd_in);
  assign active = (MY_CNT < n_active);

  // Fold this slot into the probe record: first hit, first empty, oldest.
  always_comb begin
    rec_nxt = rin;
    if (active && valid_r && (page_r == rin.page) && !rin.found) begin
      rec_nxt.found      = 1'b1;
      rec_nxt.found_slot = MY_SLOT;
      rec_nxt.found_rank = rank_r;
    end
    if (active && !valid_r && !rin.empty) begin
      rec_nxt.empty      = 1'b1;
      rec_nxt.empty_slot = MY_SLOT;
    end
    if (FIRST || (active && (rank_r > rin.worst_rank))) begin
      rec_nxt.worst_rank = rank_r;
      rec_nxt.worst_slot = MY_SLOT;
      rec_nxt.worst_page = page_r;
    end
  end

  // The record is captured only when a probe arrives, so it holds afterwards.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= rec_in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_in_vld) begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_out_vld = vld_r;
  assign rec_out     = REC_W'(rec_r);

  // Slot state: the target becomes most recent, younger slots age by one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (upd.vld) begin
      if (upd.target == MY_SLOT) begin
        valid_r <= 1'b1;
        rank_r  <= '0;
      end else if (valid_r && (!upd.was_valid || (rank_r < upd.old_rank)) &&
                   (rank_r != MAX_RANK)) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.vld && (upd.target == MY_SLOT)) begin
      page_r <= upd.page;
    end
  end

endmodule
